// ----- hw/rtl/pbea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbea_pkg
// Shared constants and types for the pad button edge / auto-repeat block.
// ----------------------------------------------------------------------------
package pbea_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int AXIS_W      = 16;
  localparam int DLY_W       = 8;
  localparam int DZ_W        = 15;
  localparam int ADDR_W      = 4;

  // Register indexes (word address paddr[3:2]).
  localparam logic [1:0] REG_FIRST_DELAY = 2'd0;
  localparam logic [1:0] REG_NEXT_DELAY  = 2'd1;
  localparam logic [1:0] REG_DEAD_ZONE   = 2'd2;

  localparam logic [DLY_W-1:0] FIRST_DELAY_RST = 8'd30;
  localparam logic [DLY_W-1:0] NEXT_DELAY_RST  = 8'd5;
  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST   = 15'd7864;

  // Repeat timing shared by all button lanes.
  typedef struct packed {
    logic [DLY_W-1:0] first_delay;
    logic [DLY_W-1:0] next_delay;
  } rpt_cfg_t;

endpackage : pbea_pkg
`default_nettype wire

// ----- hw/rtl/pbea_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbea_lane
// One button lane: the typematic counter and the repeat pulse for one button.
// ----------------------------------------------------------------------------
module pbea_lane
  import pbea_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     upd,       // successful poll request accepted
  input  wire logic     now,       // button pressed in this poll
  input  wire logic     was_held,  // button pressed at previous good poll
  input  wire rpt_cfg_t cfg,
  output logic          rpt        // repeat fires if this poll is applied
);

  logic [DLY_W-1:0] cnt;
  logic [DLY_W-1:0] cnt_next;
  logic [DLY_W-1:0] reload;
  logic             hit;

  always_comb begin
    hit = (cnt <= DLY_W'(1));
    if (!was_held && (cfg.first_delay != '0)) begin
      reload = cfg.first_delay;
    end else begin
      reload = cfg.next_delay;
    end
    if (!now) begin
      cnt_next = '0;
    end else if (hit) begin
      cnt_next = reload;
    end else begin
      cnt_next = cnt - DLY_W'(1);
    end
    rpt = now && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (upd) begin
      cnt <= cnt_next;
    end
  end

endmodule : pbea_lane
`default_nettype wire

// ----- hw/rtl/pbea_stick.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbea_stick
// Dead zone for one stick: both axes go to zero when both are centered.
// ----------------------------------------------------------------------------
module pbea_stick
  import pbea_pkg::*;
(
  input  wire logic        [AXIS_W-1:0] x,
  input  wire logic        [AXIS_W-1:0] y,
  input  wire logic        [DZ_W-1:0]   dead_zone,
  output logic             [AXIS_W-1:0] x_out,
  output logic             [AXIS_W-1:0] y_out
);

  logic [AXIS_W:0] mag_x;
  logic [AXIS_W:0] mag_y;
  logic [AXIS_W:0] dz_ext;
  logic            centered;

  // Magnitude needs one extra bit so that the most negative sample stays large.
  always_comb begin
    mag_x = x[AXIS_W-1] ? ((AXIS_W+1)'(1) << AXIS_W) - {1'b0, x} : {1'b0, x};
    mag_y = y[AXIS_W-1] ? ((AXIS_W+1)'(1) << AXIS_W) - {1'b0, y} : {1'b0, y};
    dz_ext = (AXIS_W+1)'(dead_zone);
    centered = (mag_x <= dz_ext) && (mag_y <= dz_ext);
    x_out = centered ? '0 : x;
    y_out = centered ? '0 : y;
  end

endmodule : pbea_stick
`default_nettype wire

// ----- hw/rtl/pad_button_edge_autorepeat.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pad_button_edge_autorepeat
// Controller poll conditioner: button edges, auto-repeat and stick dead zone.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_*       in   poll request: tuser = poll_ok, tdata = buttons and four axes
// m_*       out  result: tuser = connected, tdata = button bits and four axes
// apb       in   first_repeat_delay @0x0, next_repeat_delay @0x4, dead_zone @0x8
//
// One request per cycle while s_tready is high; each result is registered in the output or skid register.
// Sixteen button lanes and two stick units work in parallel on each request.
// An output register plus one skid register let one more request be accepted while
// the output stalls; s_tready drops only while the skid register is full.
// Synchronous reset clears the control state and loads the register defaults; the data registers are not reset.
// ----------------------------------------------------------------------------
module pad_button_edge_autorepeat
  import pbea_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // request stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [79:0]         s_tdata,  // button_word, left_x, left_y, right_x, right_y
  input  wire logic [0:0]          s_tuser,  // poll_ok
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [127:0]             m_tdata,  // held, press, release, repeat bits, four axes
  output logic [0:0]               m_tuser,  // connected
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  rpt_cfg_t           cfg;
  logic [DZ_W-1:0]    dead_zone;

  logic [NUM_BUTTONS-1:0] prev_held;
  logic [NUM_BUTTONS-1:0] edge_press;
  logic [NUM_BUTTONS-1:0] edge_release;
  logic [NUM_BUTTONS-1:0] edge_repeat;
  logic [4*AXIS_W-1:0]    stick_regs;

  logic                   accept;
  logic                   upd;
  logic [NUM_BUTTONS-1:0] now_bits;
  logic [NUM_BUTTONS-1:0] rpt_bits;
  logic [4*AXIS_W-1:0]    stick_new;

  logic [NUM_BUTTONS-1:0] held_next;
  logic [NUM_BUTTONS-1:0] press_next;
  logic [NUM_BUTTONS-1:0] release_next;
  logic [NUM_BUTTONS-1:0] repeat_next;
  logic [4*AXIS_W-1:0]    stick_next;
  logic                   link_next;
  logic [127:0]           res_data;

  logic [127:0]           skid_data;
  logic                   skid_link;
  logic                   skid_valid;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_delay <= FIRST_DELAY_RST;
      cfg.next_delay  <= NEXT_DELAY_RST;
      dead_zone       <= DEAD_ZONE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_FIRST_DELAY: cfg.first_delay <= pwdata[DLY_W-1:0];
        REG_NEXT_DELAY:  cfg.next_delay  <= pwdata[DLY_W-1:0];
        REG_DEAD_ZONE:   dead_zone       <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_DELAY: prdata = 32'(cfg.first_delay);
      REG_NEXT_DELAY:  prdata = 32'(cfg.next_delay);
      REG_DEAD_ZONE:   prdata = 32'(dead_zone);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Lanes
  // --------------------------------------------------------------------------
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign upd      = accept && s_tuser[0];
  assign now_bits = s_tdata[NUM_BUTTONS-1:0];

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    pbea_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .upd      (upd),
      .now      (now_bits[i]),
      .was_held (prev_held[i]),
      .cfg      (cfg),
      .rpt      (rpt_bits[i])
    );
  end

  for (genvar s = 0; s < 2; s++) begin : g_stick
    pbea_stick u_stick (
      .x         (s_tdata[16 + (2*s)*AXIS_W +: AXIS_W]),
      .y         (s_tdata[16 + (2*s+1)*AXIS_W +: AXIS_W]),
      .dead_zone (dead_zone),
      .x_out     (stick_new[(2*s)*AXIS_W +: AXIS_W]),
      .y_out     (stick_new[(2*s+1)*AXIS_W +: AXIS_W])
    );
  end

  // --------------------------------------------------------------------------
  // Merge: a failed poll keeps everything but the link flag.
  // --------------------------------------------------------------------------
  always_comb begin
    link_next = s_tuser[0];
    if (s_tuser[0]) begin
      held_next    = now_bits;
      press_next   = now_bits & ~prev_held;
      release_next = prev_held & ~now_bits;
      repeat_next  = rpt_bits;
      stick_next   = stick_new;
    end else begin
      held_next    = prev_held;
      press_next   = edge_press;
      release_next = edge_release;
      repeat_next  = edge_repeat;
      stick_next   = stick_regs;
    end
    res_data = {stick_next, repeat_next, release_next, press_next, held_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held    <= '0;
      edge_press   <= '0;
      edge_release <= '0;
      edge_repeat  <= '0;
      stick_regs   <= '0;
    end else if (accept) begin
      prev_held    <= held_next;
      edge_press   <= press_next;
      edge_release <= release_next;
      edge_repeat  <= repeat_next;
      stick_regs   <= stick_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata    <= skid_data;
        m_tuser[0] <= skid_link;
      end else if (accept) begin
        m_tdata    <= res_data;
        m_tuser[0] <= link_next;
      end
    end else if (accept) begin
      skid_data <= res_data;
      skid_link <= link_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register full while output register empty");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[31:16] & m_tdata[47:32]) == '0))
    else $error("press and release edge on the same button");

  a_repeat_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[63:48] & ~m_tdata[15:0]) == '0))
    else $error("repeat pulse on a released button");

  a_press_repeats: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[31:16] & ~m_tdata[63:48]) == '0))
    else $error("new press without a repeat pulse");

endmodule : pad_button_edge_autorepeat
`default_nettype wire
